/* rtl/core/open_address_hash_table_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the hash table core.
// ---------------------------------------------------------------------------
`ifndef OPEN_ADDRESS_HASH_TABLE_CORE_ASSERT_SVH
`define OPEN_ADDRESS_HASH_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define OAHT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define OAHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/oaht_pkg.sv */
// ---------------------------------------------------------------------------
// oaht_pkg
// Types and constants shared by the open-addressing hash table modules.
// ---------------------------------------------------------------------------
package oaht_pkg;

    // Table geometry. The table size is a power of two.
    localparam int SLOT_W      = 20;
    localparam int TABLE_SIZE  = 1 << SLOT_W;
    localparam int OUT_SLOT_W  = 20;
    localparam int DATA_W      = 32;

    // Hashing and probing constants.
    localparam int HASH_OFFSET = 10061894;
    localparam int PROBE_MOD   = 11;
    localparam int RES_W       = 4;
    localparam int SIZE_MOD    = TABLE_SIZE % PROBE_MOD;
    localparam int WRAP_ADJ    = (PROBE_MOD - SIZE_MOD) % PROBE_MOD;
    localparam logic [SLOT_W-1:0] HASH_OFS_LO = SLOT_W'(HASH_OFFSET % TABLE_SIZE);

    // Operation codes.
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value_a;
        logic signed [DATA_W-1:0] value_b;
    } t_in_item;

    typedef struct packed {
        logic                     hit;
        logic [OUT_SLOT_W-1:0]    slot;
        logic signed [DATA_W-1:0] found_a;
        logic signed [DATA_W-1:0] found_b;
        logic                     table_full;
    } t_out_item;

    // One table slot as stored in memory.
    typedef struct packed {
        logic              occupied;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] second;
    } t_slot_entry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_slot_entry       data;
    } t_wr_req;

    // Commands to the probe-step residue unit.
    typedef struct packed {
        logic start;
        logic step;
        logic wrap;
    } t_res_cmd;

endpackage

/* rtl/core/oaht_res_unit.sv */
// ---------------------------------------------------------------------------
// oaht_res_unit
// Keeps the current probe slot modulo 11. A start reduces the home slot two
// bits per cycle; a step updates the residue from the old one.
// ---------------------------------------------------------------------------
module oaht_res_unit
    import oaht_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_res_cmd          i_cmd,
    input  logic [SLOT_W-1:0] i_home,
    output logic              o_busy,
    output logic [RES_W-1:0]  o_res
);

    localparam int DIG_W     = 2;
    localparam int RES_STEPS = (SLOT_W + DIG_W - 1) / DIG_W;
    localparam int SHIFT_W   = RES_STEPS * DIG_W;
    localparam int RCNT_W    = $clog2(RES_STEPS + 1);
    localparam int RED_W     = 6;

    logic               r_busy;
    logic [RCNT_W-1:0]  r_cnt;
    logic [SHIFT_W-1:0] r_shift;
    logic [RES_W-1:0]   r_res;
    logic [RED_W-1:0]   red_in;
    logic [RED_W-1:0]   red_out;

    // Shared reducer input: next digit during reduction, 2r+1 plus the wrap correction on a step.
    always_comb begin
        if (r_busy) begin
            red_in = RED_W'({r_res, r_shift[SHIFT_W-1 -: DIG_W]});
        end else begin
            red_in = RED_W'({r_res, 1'b1}) + (i_cmd.wrap ? RED_W'(WRAP_ADJ) : '0);
        end
    end

    // Bring the value below 11 by subtracting the largest multiple of 11 (up to 33) that fits.
    always_comb begin
        if (red_in >= RED_W'(3 * PROBE_MOD)) begin
            red_out = red_in - RED_W'(3 * PROBE_MOD);
        end else if (red_in >= RED_W'(2 * PROBE_MOD)) begin
            red_out = red_in - RED_W'(2 * PROBE_MOD);
        end else if (red_in >= RED_W'(PROBE_MOD)) begin
            red_out = red_in - RED_W'(PROBE_MOD);
        end else begin
            red_out = red_in;
        end
    end

    // Sequencing of reduction and steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy  <= 1'b1;
            r_cnt   <= RCNT_W'(RES_STEPS);
            r_shift <= SHIFT_W'(i_home);
            r_res   <= '0;
        end else if (r_busy) begin
            r_res   <= RES_W'(red_out);
            r_shift <= r_shift << DIG_W;
            r_cnt   <= r_cnt - 1'b1;
            r_busy  <= (r_cnt != RCNT_W'(1));
        end else if (i_cmd.step) begin
            r_res <= RES_W'(red_out);
        end
    end

    assign o_busy = r_busy;
    assign o_res  = r_res;

endmodule

/* rtl/core/oaht_store.sv */
// ---------------------------------------------------------------------------
// oaht_store
// Slot memory: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module oaht_store
    import oaht_pkg::*;
(
    input  logic              i_clk,
    input  t_wr_req           i_wr,
    input  logic [SLOT_W-1:0] i_rd_addr,
    output t_slot_entry       o_rd_data
);

    t_slot_entry r_mem [TABLE_SIZE];
    t_slot_entry r_rd_data;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/open_address_hash_table_core.sv */
// ---------------------------------------------------------------------------
// open_address_hash_table_core
// Open-addressing hash table with insert, lookup and whole-table clear.
// ---------------------------------------------------------------------------
// Input items (func, key, value_a, value_b) are taken on i_in_valid while
// o_in_stall is low; results leave on o_out_valid and are held while
// i_out_stall is high. Every item gives exactly one result.
// Insert and lookup read one slot per cycle from the slot memory while the
// residue unit is not busy. The first probe happens the cycle after the item
// is taken. The probe step needs the slot modulo 11, which the residue unit
// derives from the home slot, so a second probe waits until that unit is no
// longer busy; later probes follow one per cycle. An item that ends on its
// first probe passes through the probe and finish states to the output
// register; a new item is taken only once the previous one leaves finish.
// Clear writes every slot, one per cycle.
// After reset the same sweep runs with o_in_stall high.
// A finished result waits in the output register while the receiver stalls;
// the next item is still accepted and runs until its own result is ready.
// ---------------------------------------------------------------------------
module open_address_hash_table_core
    import oaht_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_FINISH
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_func, n_func;
    logic [DATA_W-1:0] r_key, n_key;
    logic [DATA_W-1:0] r_val_a, n_val_a;
    logic [DATA_W-1:0] r_val_b, n_val_b;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic              r_clr_reply, n_clr_reply;
    t_out_item         r_pend, n_pend;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic [SLOT_W-1:0] home;
    logic [SLOT_W:0]   step_sum;
    t_res_cmd          res_cmd;
    logic              res_busy;
    logic [RES_W-1:0]  res;
    t_wr_req           wr;
    t_slot_entry       rd_ent;
    logic              slot_empty;
    logic              key_match;
    logic              last_probe;

    // Home slot: the table size is a power of two, so the sum of the key and
    // the offset, taken modulo the size, matches the signed remainder form.
    assign home = i_in_item.key[SLOT_W-1:0] + HASH_OFS_LO;

    // Next probe slot, with the wrap carried out of the top bit.
    assign step_sum = {1'b0, r_pos} + (SLOT_W + 1)'(res) + (SLOT_W + 1)'(1);

    assign slot_empty = !rd_ent.occupied;
    assign key_match  = (rd_ent.key == r_key);
    assign last_probe = (r_cnt == '1);

    oaht_res_unit u_res (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (res_cmd),
        .i_home  (home),
        .o_busy  (res_busy),
        .o_res   (res)
    );

    oaht_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (n_pos),
        .o_rd_data (rd_ent)
    );

    // Sequencer next-state logic.
    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_key       = r_key;
        n_val_a     = r_val_a;
        n_val_b     = r_val_b;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_clr_reply = r_clr_reply;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        res_cmd     = '0;
        wr          = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                wr.en   = 1'b1;
                wr.addr = r_pos;
                wr.data = '0;
                n_pos   = r_pos + 1'b1;
                if (r_pos == '1) begin
                    if (r_clr_reply) begin
                        n_pend  = '0;
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_in_item.func;
                    n_key   = i_in_item.key;
                    n_val_a = i_in_item.value_a;
                    n_val_b = i_in_item.value_b;
                    n_cnt   = '0;
                    case (i_in_item.func) inside
                        FUNC_INSERT, FUNC_LOOKUP: begin
                            n_pos         = home;
                            res_cmd.start = 1'b1;
                            n_state       = ST_PROBE;
                        end
                        FUNC_CLEAR: begin
                            n_pos       = '0;
                            n_clr_reply = 1'b1;
                            n_state     = ST_CLEAR;
                        end
                        default: begin
                            n_pend  = '0;
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_PROBE: begin
                n_pend = '0;
                if (r_func == FUNC_INSERT && slot_empty) begin
                    // Free slot: store the item here.
                    wr.en         = 1'b1;
                    wr.addr       = r_pos;
                    wr.data       = '{occupied: 1'b1, key: r_key,
                                      first: r_val_a, second: r_val_b};
                    n_pend.hit    = 1'b1;
                    n_pend.slot   = OUT_SLOT_W'(r_pos);
                    n_state       = ST_FINISH;
                end else if (r_func != FUNC_INSERT && slot_empty) begin
                    // Lookup reached an empty slot: miss.
                    n_state = ST_FINISH;
                end else if (r_func != FUNC_INSERT && key_match) begin
                    n_pend.hit     = 1'b1;
                    n_pend.slot    = OUT_SLOT_W'(r_pos);
                    n_pend.found_a = rd_ent.first;
                    n_pend.found_b = rd_ent.second;
                    n_state        = ST_FINISH;
                end else if (last_probe) begin
                    // As many probes as the table has slots have been made.
                    n_pend.table_full = (r_func == FUNC_INSERT);
                    n_state           = ST_FINISH;
                end else if (!res_busy) begin
                    n_pos        = step_sum[SLOT_W-1:0];
                    n_cnt        = r_cnt + 1'b1;
                    res_cmd.step = 1'b1;
                    res_cmd.wrap = step_sum[SLOT_W];
                end
            end

            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    n_clr_reply = 1'b0;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs. Reset starts the clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_pos       <= '0;
            r_cnt       <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_func      <= n_func;
            r_key       <= n_key;
            r_val_a     <= n_val_a;
            r_val_b     <= n_val_b;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_clr_reply <= n_clr_reply;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `include "open_address_hash_table_core_assert.svh"

    // A new result appears only when the sequencer hands one over.
    `OAHT_ASSERT_NEXT(a_out_from_finish, (r_state != ST_FINISH) && !r_out_valid,
        !r_out_valid, "result appeared without a finished item")

    // The probe position advances only once the residue is known.
    `OAHT_ASSERT_NOW(a_step_needs_res, res_cmd.step, !res_busy && (r_state == ST_PROBE),
        "probe step taken while residue was still being reduced")

    // The memory is written only by the clearing sweep or an insert.
    `OAHT_ASSERT_NOW(a_write_source, wr.en,
        (r_state == ST_CLEAR) || ((r_state == ST_PROBE) && (r_func == FUNC_INSERT)),
        "slot memory written outside clear or insert")

    // An accepted item always moves the sequencer out of idle.
    `OAHT_ASSERT_NEXT(a_accept_leaves_idle, i_in_valid && !o_in_stall,
        r_state != ST_IDLE, "accepted item left the sequencer idle")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Hash table core testbench
// Drives insert, lookup, clear and unused-code items through the valid/stall
// input channel and checks every result item against a sparse behavioral
// model of the open-addressing table. Keys are clustered on a few home slots
// so that probe chains, duplicates and the wrap at the last slot are
// exercised. Both channels idle in random bursts.
// ---------------------------------------------------------------------------
module testbench;
    import oaht_pkg::*;

    localparam logic [1:0] FUNC_NOOP = 2'd3;

    // Clock, reset and the block's inputs, all known from time zero.
    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      in_valid   = 1'b0;
    t_in_item  in_item    = '0;
    logic      out_stall  = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Items waiting to be driven and results waiting to arrive.
    t_in_item  queued_requests[$];
    t_out_item pending_responses[$];

    // Model of the table: a slot is occupied when it exists in the array.
    t_slot_entry stored_slots[int];

    // Idle bursts on both channels.
    int in_gap    = 0;
    int stall_run = 0;

    // Tallies for the summary.
    int mismatches   = 0;
    int checked      = 0;
    int n_insert     = 0;
    int n_insert_ok  = 0;
    int n_lookup     = 0;
    int n_lookup_hit = 0;
    int n_clear      = 0;
    int n_noop       = 0;

    open_address_hash_table_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    // Home slot: truncating remainder of the key, plus the offset, modulo
    // the table size.
    function automatic int home_index(logic signed [DATA_W-1:0] key);
        longint r;
        longint h;
        r = longint'(key) % longint'(TABLE_SIZE);
        h = (r + longint'(HASH_OFFSET)) % longint'(TABLE_SIZE);
        if (h < 0) begin
            h += TABLE_SIZE;
        end
        return int'(h);
    endfunction

    function automatic int next_index(int cur);
        int n;
        n = cur + (cur % PROBE_MOD) + 1;
        if (n >= TABLE_SIZE) begin
            n -= TABLE_SIZE;
        end
        return n;
    endfunction

    // Apply one item to the model table and return the result it gives.
    function automatic t_out_item hash_table_response(t_in_item it);
        t_out_item   resp;
        t_slot_entry entry;
        int          pos;
        bit          done;
        resp = '0;
        done = 1'b0;
        case (it.func)
            FUNC_INSERT: begin
                n_insert++;
                pos = home_index(it.key);
                for (int n = 0; n < TABLE_SIZE && !done; n++) begin
                    if (!stored_slots.exists(pos)) begin
                        entry.occupied = 1'b1;
                        entry.key      = it.key;
                        entry.first    = it.value_a;
                        entry.second   = it.value_b;
                        stored_slots[pos] = entry;
                        resp.hit  = 1'b1;
                        resp.slot = OUT_SLOT_W'(pos);
                        done = 1'b1;
                    end else begin
                        pos = next_index(pos);
                    end
                end
                if (done) begin
                    n_insert_ok++;
                end else begin
                    resp.table_full = 1'b1;
                end
            end
            FUNC_LOOKUP: begin
                n_lookup++;
                pos = home_index(it.key);
                for (int n = 0; n < TABLE_SIZE && !done; n++) begin
                    if (!stored_slots.exists(pos)) begin
                        done = 1'b1;
                    end else if (stored_slots[pos].key == it.key) begin
                        resp.hit     = 1'b1;
                        resp.slot    = OUT_SLOT_W'(pos);
                        resp.found_a = stored_slots[pos].first;
                        resp.found_b = stored_slots[pos].second;
                        n_lookup_hit++;
                        done = 1'b1;
                    end else begin
                        pos = next_index(pos);
                    end
                end
            end
            FUNC_CLEAR: begin
                n_clear++;
                stored_slots.delete();
            end
            default: begin
                n_noop++;
            end
        endcase
        return resp;
    endfunction

    task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, got %0h", field, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic queue_request(logic [1:0] f, logic [31:0] k, logic [31:0] a,
                                 logic [31:0] b);
        t_in_item it;
        it.func    = f;
        it.key     = k;
        it.value_a = a;
        it.value_b = b;
        queued_requests.push_back(it);
    endtask

    // Input driver: holds an item until accepted, otherwise idles in bursts
    // while plenty of items remain.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end else if (queued_requests.size() > 60 && $urandom_range(0, 4) == 0) begin
                in_valid <= 1'b0;
                in_gap   <= $urandom_range(0, 5);
            end else if (queued_requests.size() != 0) begin
                in_valid <= 1'b1;
                in_item  <= queued_requests.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall: random bursts, none near the end of the run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end else if (stall_run > 0) begin
            out_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end else if (queued_requests.size() > 60 && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_run <= $urandom_range(0, 5);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: predicts on each accepted item and checks each result item.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                pending_responses.push_back(hash_table_response(in_item));
            end
            if (o_out_valid && !out_stall) begin
                if (pending_responses.size() == 0) begin
                    $error("result item with no expectation waiting");
                    mismatches++;
                end else begin
                    want = pending_responses.pop_front();
                    check_field("hit", want.hit, o_out_item.hit);
                    check_field("slot", want.slot, o_out_item.slot);
                    check_field("found_a", want.found_a, o_out_item.found_a);
                    check_field("found_b", want.found_b, o_out_item.found_b);
                    check_field("table_full", want.table_full, o_out_item.table_full);
                    checked++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [19:0] low_pool[8];
        logic [31:0] used_keys[$];
        logic [31:0] k;
        int          r;

        // Low key bits that decide the home slot: last slot, slot zero,
        // the extremes and a few random ones.
        low_pool[0] = 20'd423865;
        low_pool[1] = 20'd423866;
        low_pool[2] = 20'd0;
        low_pool[3] = 20'hFFFFF;
        for (int i = 4; i < 8; i++) begin
            low_pool[i] = 20'($urandom_range(0, TABLE_SIZE - 1));
        end

        // Directed part: empty lookup, extreme keys and values, collisions,
        // wrap past the last slot, duplicates, chain miss, no-op and clear.
        queue_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 32'h0);
        queue_request(FUNC_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_request(FUNC_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_request(FUNC_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_request(FUNC_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_request(FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0, 32'h0);
        queue_request(FUNC_LOOKUP, 32'h8000_0000, 32'h0, 32'h0);
        queue_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 32'h0);
        queue_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
        queue_request(FUNC_INSERT, 32'd423865, 32'h1234_5678, 32'h9ABC_DEF0);
        queue_request(FUNC_INSERT, 32'd423865 + TABLE_SIZE, 32'h5555_5555, 32'hAAAA_AAAA);
        queue_request(FUNC_INSERT, 32'd423866, 32'hAAAA_AAAA, 32'h5555_5555);
        queue_request(FUNC_LOOKUP, 32'd423865 + TABLE_SIZE, 32'h0, 32'h0);
        queue_request(FUNC_LOOKUP, 32'd423866, 32'h0, 32'h0);
        queue_request(FUNC_INSERT, 32'h0000_0000, 32'h0BAD_F00D, 32'h0000_0001);
        queue_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 32'h0);
        queue_request(FUNC_LOOKUP, TABLE_SIZE, 32'h0, 32'h0);
        queue_request(FUNC_NOOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(FUNC_CLEAR, 32'h0, 32'h0, 32'h0);
        queue_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 32'h0);
        queue_request(FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0, 32'h0);
        queue_request(FUNC_INSERT, 32'h0000_0000, 32'h0, 32'h0);
        queue_request(FUNC_LOOKUP, 32'h0000_0000, 32'h0, 32'h0);

        // Random part: mostly clustered inserts and lookups of stored keys,
        // with one clear of a populated table in the middle.
        for (int i = 0; i < 525; i++) begin
            r = $urandom_range(0, 99);
            k = $urandom;
            if (i == 300) begin
                queue_request(FUNC_CLEAR, $urandom, $urandom, $urandom);
            end else if (r < 3) begin
                queue_request(FUNC_NOOP, k, $urandom, $urandom);
            end else if (r < 50) begin
                if ($urandom_range(0, 9) < 7) begin
                    k[19:0] = low_pool[$urandom_range(0, 7)];
                end
                used_keys.push_back(k);
                queue_request(FUNC_INSERT, k, $urandom, $urandom);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55 && used_keys.size() != 0) begin
                    k = used_keys[$urandom_range(0, used_keys.size() - 1)];
                end else if (r < 80) begin
                    k[19:0] = low_pool[$urandom_range(0, 7)];
                end
                queue_request(FUNC_LOOKUP, k, $urandom, $urandom);
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything driven, accepted and answered.
        while (queued_requests.size() != 0 || in_valid || pending_responses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("Checked %0d results: %0d inserts (%0d stored), %0d lookups (%0d hits),",
                 checked, n_insert, n_insert_ok, n_lookup, n_lookup_hit);
        $display("%0d table clears and %0d unused-code items.", n_clear, n_noop);
        if (mismatches == 0 && pending_responses.size() == 0) begin
            $display("open_address_hash_table_core: match");
        end else begin
            $display("open_address_hash_table_core: mismatch");
        end
        $finish;
    end

    // Watchdog: covers the reset sweep, two full clears and slow probing.
    initial begin
        #320000000;
        $display("open_address_hash_table_core: mismatch");
        $finish;
    end

endmodule
